>>> src/bnh_pkg.sv
// Shared types and constants for the next-hop router.
package bnh_pkg;

	localparam int NODE_W     = 4;
	localparam int LPORT_W    = 2;
	localparam int PORT_W     = 3;
	localparam int OUT_PORT_W = 3;
	localparam int STATUS_W   = 2;
	localparam int NS_W       = 5;
	localparam int NP_W       = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam int DEF_MAX_SWITCHES = 16;
	localparam int DEF_MAX_PORTS    = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_SWITCHES = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PORTS    = 1'b1;

	localparam logic [NS_W-1:0] SWITCHES_RST = 5'd16;
	localparam logic [NP_W-1:0] PORTS_RST    = 3'd4;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SAME    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNREACH = 2'd2;

	typedef struct packed {
		logic                operation;
		logic [NODE_W-1:0]   link_switch;
		logic [LPORT_W-1:0]  link_port;
		logic [NODE_W-1:0]   link_neighbor;
		logic [NODE_W-1:0]   source_node;
		logic                source_is_host;
		logic [NODE_W-1:0]   dest_node;
		logic                dest_is_host;
	} bnh_req_t;

	typedef struct packed {
		logic [OUT_PORT_W-1:0] out_port;
		logic [STATUS_W-1:0]   route_status;
	} bnh_rsp_t;

endpackage

>>> src/bnh_stream_if.sv
// Valid/ready stream channel carrying one word of a given type.
interface bnh_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> src/bnh_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bnh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> src/bfs_next_hop_router.sv
// Next-hop router: link table plus breadth-first search per query.
//
//  channel | dir | handshake        | word
//  --------+-----+------------------+-------------------------------------------
//  req     | in  | valid/ready      | bnh_req_t: link write or next-hop query
//  rsp     | out | valid/ready      | bnh_rsp_t: out_port, route_status
//  cfg     | in  | cfg_we, no ready | cfg_index selects register, cfg_wdata value
//
// A link write leaves the input free; a query holds it off until its result
// moves into the output register. A search reads the source's links first,
// one link table read per port in use, then pops switches from the queue,
// checks each for the target and reads its links the same way, until the
// target is popped or the queue runs empty.
// Reset: clears control, counters and visited mask; the link table holds
// nothing until written and needs no clearing pass.
// Stalls: a finished result waits in the output register while the next word
// is accepted; only the move of a new result into it waits on rsp.ready.
module bfs_next_hop_router #(
	parameter int MAX_SWITCHES = bnh_pkg::DEF_MAX_SWITCHES,
	parameter int MAX_PORTS    = bnh_pkg::DEF_MAX_PORTS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bnh_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bnh_pkg::CFG_DATA_W-1:0] cfg_wdata,
	bnh_stream_if.sink                     req,
	bnh_stream_if.source                   rsp
);
	import bnh_pkg::*;

	localparam int LT_DEPTH = MAX_SWITCHES * MAX_PORTS;
	localparam int LT_AW    = $clog2(LT_DEPTH);
	localparam int Q_DEPTH  = MAX_SWITCHES;
	localparam int Q_AW     = $clog2(Q_DEPTH);
	localparam int VIS_N    = 2 ** NODE_W;

	// Controller states
	localparam logic [1:0] S_IDLE = 2'd0;	// take words
	localparam logic [1:0] S_EXP  = 2'd1;	// read the links of the current switch
	localparam logic [1:0] S_POPW = 2'd2;	// queue head arrives, check for target
	localparam logic [1:0] S_EMIT = 2'd3;	// hand result to the output register

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [PORT_W-1:0] port;
	} qent_t;

	// Configuration
	logic [NS_W-1:0] sw_cfg_q;
	logic [NP_W-1:0] pt_cfg_q;
	logic [NS_W-1:0] ns;
	logic [NP_W-1:0] np;

	// Search state
	logic [1:0]        state_q;
	logic [VIS_N-1:0]  visited_q;
	logic [Q_AW-1:0]   head_q;
	logic [Q_AW-1:0]   tail_q;
	logic [NODE_W-1:0] cur_node_q;
	logic [PORT_W-1:0] cur_tag_q;
	logic              is_src_q;
	logic [NODE_W-1:0] dst_q;
	logic [NP_W-1:0]   port_idx_q;
	logic              rd_valid_s1;
	logic [PORT_W-1:0] rd_port_s1;
	logic              fwd_s1;
	qent_t             fwd_data_s1;
	bnh_rsp_t          res_q;
	logic              rsp_valid_q;
	bnh_rsp_t          rsp_data_q;

	// Memory ports
	logic              lt_we;
	logic [LT_AW-1:0]  lt_waddr;
	logic [LT_AW-1:0]  lt_raddr;
	logic [NODE_W-1:0] lt_rdata;
	logic              q_we;
	qent_t             q_wdata;
	qent_t             q_rdata;

	// Decode
	logic              req_fire;
	logic              query_acc;
	logic              special;
	bnh_rsp_t          spec_res;
	logic [NODE_W-1:0] nb;
	logic              enq;
	logic [PORT_W-1:0] tag;
	logic [Q_AW-1:0]   tail_nx;
	logic              issue;
	logic              exp_final;
	logic              pop_more;
	qent_t             pop_ent;
	logic              pop_hit;
	logic              emit_go;
	logic [NODE_W-1:0] lt_rnode;
	logic [NP_W-1:0]   lt_rport;

	// Clamp the configured counts to the supported range
	always_comb begin
		if (sw_cfg_q == '0) begin
			ns = NS_W'(1);
		end else if (int'(sw_cfg_q) > MAX_SWITCHES) begin
			ns = NS_W'(MAX_SWITCHES);
		end else begin
			ns = sw_cfg_q;
		end
		if (pt_cfg_q == '0) begin
			np = NP_W'(1);
		end else if (int'(pt_cfg_q) > MAX_PORTS) begin
			np = NP_W'(MAX_PORTS);
		end else begin
			np = pt_cfg_q;
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign query_acc = req_fire && (req.data.operation == OP_QUERY);

	// Queries answered without a search: host source, out-of-range ends,
	// same switch, and a host that no switch owns
	always_comb begin
		special  = 1'b1;
		spec_res = '{out_port: '0, route_status: ST_FOUND};
		if (req.data.source_is_host) begin
			spec_res.route_status = ST_FOUND;
		end else if (!(NS_W'(req.data.source_node) < ns)) begin
			spec_res.route_status = ST_UNREACH;
		end else if (req.data.dest_node == req.data.source_node) begin
			if (req.data.dest_is_host) begin
				spec_res.out_port = OUT_PORT_W'(np);
			end else begin
				spec_res.route_status = ST_SAME;
			end
		end else if (!(NS_W'(req.data.dest_node) < ns)) begin
			spec_res.route_status = req.data.dest_is_host ? ST_SAME : ST_UNREACH;
		end else begin
			special = 1'b0;
		end
	end

	// Link table write; drop writes outside the table
	assign lt_we = req_fire && (req.data.operation == OP_WRITE)
		&& (int'(req.data.link_switch) < MAX_SWITCHES)
		&& (int'(req.data.link_port) < MAX_PORTS);
	assign lt_waddr = LT_AW'(int'(req.data.link_switch) * MAX_PORTS
		+ int'(req.data.link_port));

	// Link returned for the port read last cycle: queue it if new and in range
	assign nb      = lt_rdata;
	assign enq     = (state_q == S_EXP) && rd_valid_s1 && (NS_W'(nb) < ns) && !visited_q[nb];
	assign tag     = is_src_q ? rd_port_s1 : cur_tag_q;
	assign q_we    = enq;
	assign q_wdata = '{node: nb, port: tag};
	assign tail_nx = tail_q + Q_AW'(enq);

	assign issue     = (port_idx_q < np);
	assign exp_final = (state_q == S_EXP) && !issue;
	assign pop_more  = (head_q != tail_nx);

	// Forward an entry written in the same cycle the head was read
	assign pop_ent = fwd_s1 ? fwd_data_s1 : q_rdata;
	assign pop_hit = (state_q == S_POPW) && (pop_ent.node == dst_q);
	assign emit_go = (state_q == S_EMIT) && (!rsp_valid_q || rsp.ready);

	// A popped switch starts its port 0 read straight from the queue data
	assign lt_rnode = (state_q == S_POPW) ? pop_ent.node : cur_node_q;
	assign lt_rport = (state_q == S_POPW) ? '0 : port_idx_q;
	assign lt_raddr = LT_AW'(int'(lt_rnode) * MAX_PORTS + int'(lt_rport));

	bnh_ram #(
		.WIDTH (NODE_W),
		.DEPTH (LT_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (lt_we),
		.waddr (lt_waddr),
		.wdata (req.data.link_neighbor),
		.raddr (lt_raddr),
		.rdata (lt_rdata)
	);

	bnh_ram #(
		.WIDTH ($bits(qent_t)),
		.DEPTH (Q_DEPTH)
	) u_queue_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (tail_q),
		.wdata (q_wdata),
		.raddr (head_q),
		.rdata (q_rdata)
	);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			sw_cfg_q    <= SWITCHES_RST;
			pt_cfg_q    <= PORTS_RST;
			rsp_valid_q <= 1'b0;
			rd_valid_s1 <= 1'b0;
			fwd_s1      <= 1'b0;
			visited_q   <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			port_idx_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_SWITCHES: sw_cfg_q <= cfg_wdata;
					CFG_PORTS:    pt_cfg_q <= cfg_wdata[NP_W-1:0];
					default: ;
				endcase
			end
			if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			fwd_s1      <= q_we && (tail_q == head_q);
			rd_valid_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (query_acc) begin
						if (special) begin
							state_q <= S_EMIT;
						end else begin
							visited_q  <= VIS_N'(1) << req.data.source_node;
							head_q     <= '0;
							tail_q     <= '0;
							port_idx_q <= '0;
							state_q    <= S_EXP;
						end
					end
				end
				S_EXP: begin
					if (enq) begin
						visited_q[nb] <= 1'b1;
						tail_q        <= tail_nx;
					end
					if (issue) begin
						rd_valid_s1 <= 1'b1;
						port_idx_q  <= port_idx_q + NP_W'(1);
					end else if (pop_more) begin
						head_q  <= head_q + Q_AW'(1);
						state_q <= S_POPW;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_POPW: begin
					if (pop_hit) begin
						state_q <= S_EMIT;
					end else begin
						rd_valid_s1 <= 1'b1;
						port_idx_q  <= NP_W'(1);
						state_q     <= S_EXP;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		fwd_data_s1 <= q_wdata;
		if (query_acc) begin
			dst_q      <= req.data.dest_node;
			cur_node_q <= req.data.source_node;
			is_src_q   <= 1'b1;
			res_q      <= spec_res;
		end
		if ((state_q == S_EXP) && issue) begin
			rd_port_s1 <= PORT_W'(port_idx_q);
		end
		if (exp_final && !pop_more) begin
			res_q <= '{out_port: '0, route_status: ST_UNREACH};
		end
		if (pop_hit) begin
			res_q <= '{out_port: OUT_PORT_W'(pop_ent.port), route_status: ST_FOUND};
		end else if (state_q == S_POPW) begin
			cur_node_q <= pop_ent.node;
			cur_tag_q  <= pop_ent.port;
			is_src_q   <= 1'b0;
			rd_port_s1 <= '0;
		end
		if (emit_go) begin
			rsp_data_q <= res_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

>>> src/bnh_checker.sv
// Port-level checks for the next-hop router, bound to the top level.
module bnh_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input bnh_pkg::bnh_req_t req_data,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input bnh_pkg::bnh_rsp_t rsp_data
);
	import bnh_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result word changed while stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_data.route_status == ST_FOUND)
			|| (rsp_data.route_status == ST_SAME)
			|| (rsp_data.route_status == ST_UNREACH))
		else $error("unknown route status");

	a_port_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.route_status != ST_FOUND) |-> (rsp_data.out_port == '0))
		else $error("port not zero on a failed route");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_data.operation == OP_QUERY) |=> !req_ready)
		else $error("query word did not hold off the next word");

	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_data.operation == OP_WRITE) |=> req_ready)
		else $error("link write did not free the input at once");

endmodule

bind bfs_next_hop_router bnh_checker u_bnh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_data  (req.data),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

>>> bench/testbench.sv
// Self-checking bench for the next-hop router: link table writes and routed queries.
`timescale 1ns / 1ps

module testbench;
	import bnh_pkg::*;

	localparam int MAXS          = DEF_MAX_SWITCHES;
	localparam int MAXP          = DEF_MAX_PORTS;
	localparam int REQ_W         = $bits(bnh_req_t);
	// Give a full search at 16 switches and 4 ports room, plus the worst
	// receiver stall, before touching the registers.
	localparam int SETTLE_CYCLES = 120;
	localparam int QUIET_LIMIT   = 3000;

	// Shadow of everything the block holds between words: the link table, which
	// entries have been written, and both registers as written (unclamped).
	typedef struct packed {
		logic [MAXS*MAXP*NODE_W-1:0] link;
		logic [MAXS*MAXP-1:0]        written;
		logic [NS_W-1:0]             switches;
		logic [NP_W-1:0]             ports;
	} fabric_t;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_PATTERN
	} ready_mode_e;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we      = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index   = CFG_SWITCHES;
	logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
	logic                  word_valid  = 1'b0;
	bnh_req_t              word_out    = '0;
	logic                  answer_ready = 1'b0;

	bnh_stream_if #(.T(bnh_req_t)) req_ch ();
	bnh_stream_if #(.T(bnh_rsp_t)) rsp_ch ();

	assign req_ch.valid = word_valid;
	assign req_ch.data  = word_out;
	assign rsp_ch.ready = answer_ready;

	bfs_next_hop_router dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// plan tracks the table as the stimulus is built; live tracks it as words
	// are actually accepted and feeds the expected answers.
	fabric_t     plan;
	fabric_t     live;
	bit          live_blank;
	bnh_req_t    pending_words [$];
	bnh_rsp_t    route_expect [$];
	bnh_rsp_t    answer_due;

	int unsigned burst_left = 1;
	int unsigned gap_left   = 0;
	ready_mode_e stall_mode = READY_ALWAYS;
	int unsigned stall_span = 0;
	logic [15:0] stall_pattern = 16'b1100_1010_0001_0111;
	int unsigned quiet_cycles = 0;

	int unsigned mismatches = 0;
	int unsigned links_written = 0;
	int unsigned queries_sent = 0;
	int unsigned ports_found = 0;
	int unsigned same_answers = 0;
	int unsigned unreachable_answers = 0;
	int unsigned settings_seen = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// ---------------------------------------------------------------- predictor

	function automatic int switches_used(input fabric_t f);
		if (f.switches < 1) return 1;
		if (f.switches > MAXS) return MAXS;
		return f.switches;
	endfunction

	function automatic int ports_used(input fabric_t f);
		if (f.ports < 1) return 1;
		if (f.ports > MAXP) return MAXP;
		return f.ports;
	endfunction

	function automatic fabric_t with_link(input fabric_t f, input bnh_req_t w);
		int idx;
		idx = w.link_switch * MAXP + w.link_port;
		f.link[idx*NODE_W +: NODE_W] = w.link_neighbor;
		f.written[idx] = 1'b1;
		return f;
	endfunction

	// Work out the answer to one query. blank_read flags a search that would
	// touch a table entry never written, which the stimulus must not cause.
	function automatic bnh_rsp_t route_next_hop(input fabric_t f, input bnh_req_t q,
			output bit blank_read);
		bnh_rsp_t          answer;
		int                ns, np, node, first, head, tail, idx, p;
		logic [NODE_W-1:0] nb;
		logic [MAXS-1:0]   seen;
		int                hop_node [MAXS];
		int                hop_port [MAXS];
		bit                searching;
		ns = switches_used(f);
		np = ports_used(f);
		answer.out_port = '0;
		answer.route_status = ST_FOUND;
		blank_read = 1'b0;
		if (q.source_is_host) begin
			// a host has a single uplink, always port 0
		end else if (q.source_node >= ns) begin
			answer.route_status = ST_UNREACH;
		end else if (q.dest_node == q.source_node) begin
			if (q.dest_is_host)
				answer.out_port = OUT_PORT_W'(np);
			else
				answer.route_status = ST_SAME;
		end else if (q.dest_node >= ns) begin
			// a host nobody owns counts as already there
			answer.route_status = q.dest_is_host ? ST_SAME : ST_UNREACH;
		end else begin
			seen = '0;
			seen[q.source_node] = 1'b1;
			node = q.source_node;
			first = -1;
			head = 0;
			tail = 0;
			searching = 1'b1;
			while (searching) begin
				// expand node; neighbours off the topology are skipped
				for (p = 0; p < np; p++) begin
					idx = node * MAXP + p;
					if (!f.written[idx])
						blank_read = 1'b1;
					nb = f.link[idx*NODE_W +: NODE_W];
					if (nb < ns && !seen[nb] && tail < MAXS) begin
						seen[nb] = 1'b1;
						hop_node[tail] = nb;
						hop_port[tail] = (first < 0) ? p : first;
						tail++;
					end
				end
				if (head >= tail) begin
					answer.route_status = ST_UNREACH;
					searching = 1'b0;
				end else begin
					node = hop_node[head];
					first = hop_port[head];
					head++;
					if (node == q.dest_node) begin
						answer.out_port = OUT_PORT_W'(first);
						searching = 1'b0;
					end
				end
			end
		end
		return answer;
	endfunction

	// ---------------------------------------------------------------- stimulus

	function automatic bnh_req_t random_word();
		logic [REQ_W-1:0] raw;
		raw = REQ_W'($urandom);
		return raw;
	endfunction

	// Unused fields carry random bits so that every field bit toggles.
	function automatic bnh_req_t link_word(input int sw, input int pt, input int nb);
		bnh_req_t w;
		w = random_word();
		w.operation     = OP_WRITE;
		w.link_switch   = NODE_W'(sw);
		w.link_port     = LPORT_W'(pt);
		w.link_neighbor = NODE_W'(nb);
		return w;
	endfunction

	function automatic bnh_req_t route_query(input int src, input bit src_host,
			input int dst, input bit dst_host);
		bnh_req_t w;
		w = random_word();
		w.operation      = OP_QUERY;
		w.source_node    = NODE_W'(src);
		w.source_is_host = src_host;
		w.dest_node      = NODE_W'(dst);
		w.dest_is_host   = dst_host;
		return w;
	endfunction

	// Favour self-loops and ring links so that the graph stays sparse and the
	// paths long; now and then point off the topology.
	function automatic int pick_neighbor(input int sw, input int ns);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 35) return sw;
		if (roll < 60) return (sw + 1) % ns;
		if (roll < 75) return (sw + ns - 1) % ns;
		if (roll < 92) return $urandom_range(0, ns - 1);
		return $urandom_range(0, MAXS - 1);
	endfunction

	// Queue a word unless it is a query whose search would read an empty entry.
	function automatic bit offer_word(input bnh_req_t w);
		bit       blank;
		bnh_rsp_t ignored;
		if (w.operation == OP_WRITE) begin
			plan = with_link(plan, w);
		end else begin
			ignored = route_next_hop(plan, w, blank);
			if (blank)
				return 1'b0;
		end
		pending_words.insert(pending_words.size(), w);
		return 1'b1;
	endfunction

	// Hold the sender until every answer is back, then let the block go idle.
	task automatic settle();
		while (pending_words.size() != 0 || word_valid || route_expect.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_SWITCHES) begin
			plan.switches = NS_W'(value);
			live.switches = NS_W'(value);
		end else begin
			plan.ports = NP_W'(value);
			live.ports = NP_W'(value);
		end
	endtask

	task automatic set_topology(input int switches, input int ports);
		write_register(CFG_SWITCHES, switches);
		write_register(CFG_PORTS, ports);
		settings_seen++;
		@(negedge clk);
	endtask

	task automatic random_phase(input int budget);
		int ns, np, offered, sw, pt, roll, src, dst;
		ns = switches_used(plan);
		np = ports_used(plan);
		offered = 0;
		// complete the live part of the table first so searches can run deep
		for (sw = 0; sw < ns; sw++)
			for (pt = 0; pt < np; pt++)
				if (!plan.written[sw*MAXP + pt]) begin
					void'(offer_word(link_word(sw, pt, pick_neighbor(sw, ns))));
					offered++;
				end
		while (offered < budget) begin
			roll = $urandom_range(0, 99);
			if (roll < 28) begin
				// rewrite a link, sometimes on a port or switch outside the topology
				sw = (roll < 3) ? $urandom_range(0, MAXS - 1) : $urandom_range(0, ns - 1);
				pt = $urandom_range(0, MAXP - 1);
				offered += offer_word(link_word(sw, pt, pick_neighbor(sw, ns)));
			end else if (roll < 90) begin
				src = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAXS - 1)
					: $urandom_range(0, ns - 1);
				dst = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MAXS - 1)
					: $urandom_range(0, ns - 1);
				offered += offer_word(route_query(src, $urandom_range(0, 9) == 0,
					dst, $urandom_range(0, 3) == 0));
			end else begin
				offered += offer_word(random_word());
			end
		end
		settle();
	endtask

	initial begin
		arst_n = 1'b0;
		plan = '0;
		live = '0;
		live.switches = SWITCHES_RST;
		live.ports = PORTS_RST;
		plan.switches = SWITCHES_RST;
		plan.ports = PORTS_RST;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: widest topology, a small hand-built fabric on switches 0..3.
		set_topology(16, 4);
		void'(offer_word(route_query(15, 1'b1, 0, 1'b1)));   // host source
		void'(offer_word(route_query(7, 1'b0, 7, 1'b0)));    // same switch
		void'(offer_word(route_query(15, 1'b0, 15, 1'b1)));  // host on own switch
		void'(offer_word(link_word(0, 0, 1)));
		void'(offer_word(link_word(0, 1, 0)));
		void'(offer_word(link_word(0, 2, 0)));
		void'(offer_word(link_word(0, 3, 0)));
		void'(offer_word(link_word(1, 0, 0)));
		void'(offer_word(link_word(1, 1, 1)));
		void'(offer_word(link_word(1, 2, 1)));
		void'(offer_word(link_word(1, 3, 2)));
		void'(offer_word(link_word(2, 0, 1)));
		void'(offer_word(link_word(2, 1, 3)));
		void'(offer_word(link_word(2, 2, 2)));
		void'(offer_word(link_word(2, 3, 2)));
		void'(offer_word(link_word(3, 0, 3)));
		void'(offer_word(link_word(3, 1, 3)));
		void'(offer_word(link_word(3, 2, 2)));
		void'(offer_word(link_word(3, 3, 3)));
		void'(offer_word(route_query(0, 1'b0, 3, 1'b0)));    // three hops out on port 0
		void'(offer_word(route_query(3, 1'b0, 0, 1'b0)));    // back again on port 2
		void'(offer_word(route_query(1, 1'b0, 0, 1'b1)));    // host on a neighbour
		void'(offer_word(route_query(2, 1'b0, 1, 1'b0)));
		void'(offer_word(route_query(0, 1'b0, 9, 1'b0)));    // cut off from 0..3
		void'(offer_word(route_query(3, 1'b0, 3, 1'b1)));
		settle();

		random_phase(110);

		set_topology(1, 1);
		random_phase(30);

		// Out-of-range source, unowned host, out-of-range destination.
		set_topology(5, 2);
		void'(offer_word(route_query(9, 1'b0, 1, 1'b0)));
		void'(offer_word(route_query(1, 1'b0, 12, 1'b1)));
		void'(offer_word(route_query(0, 1'b0, 12, 1'b0)));
		random_phase(50);

		// Register values past both ends of the range clamp to the limits.
		set_topology(0, 0);
		random_phase(25);
		set_topology(9, 3);
		random_phase(60);
		set_topology(31, 7);
		random_phase(60);
		set_topology(16, 1);
		random_phase(35);
		set_topology(2, 4);
		random_phase(35);

		$display("Covered %0d link writes and %0d queries over %0d register settings.",
			links_written, queries_sent, settings_seen);
		$display("Answers: %0d ports found, %0d same node, %0d unreachable.",
			ports_found, same_answers, unreachable_answers);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// ---------------------------------------------------------------- driver

	// Send pending words in bursts of random length with random gaps between
	// them; a word once offered stays put until the block takes it.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_valid <= 1'b0;
			word_out   <= '0;
			burst_left <= 1;
			gap_left   <= 0;
		end else begin
			if (word_valid && req_ch.ready) begin
				// Advance the shadow and, for a query, book the answer it owes.
				if (word_out.operation == OP_WRITE) begin
					live = with_link(live, word_out);
					links_written++;
				end else begin
					route_expect.insert(route_expect.size(),
						route_next_hop(live, word_out, live_blank));
					queries_sent++;
				end
			end
			if (!word_valid || req_ch.ready) begin
				if (gap_left != 0 || pending_words.size() == 0) begin
					word_valid <= 1'b0;
					if (gap_left != 0)
						gap_left <= gap_left - 1;
				end else begin
					word_valid <= 1'b1;
					word_out   <= pending_words.pop_front();
					if (burst_left > 1) begin
						burst_left <= burst_left - 1;
					end else begin
						// a quarter of bursts run straight on with no gap
						burst_left <= $urandom_range(1, 24);
						gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	// Check each accepted answer against the oldest one booked, and stall the
	// result channel: always ready, coin toss, or a rotating pattern, switching
	// to a random mode whenever a random span runs out.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			answer_ready  <= 1'b0;
			stall_mode    <= READY_ALWAYS;
			stall_span    <= 0;
			stall_pattern <= 16'b1100_1010_0001_0111;
		end else begin
			if (rsp_ch.valid && answer_ready) begin
				if (route_expect.size() == 0) begin
					$error("answer out_port=%0d route_status=%0d arrived with none due",
						rsp_ch.data.out_port, rsp_ch.data.route_status);
					mismatches++;
				end else begin
					answer_due = route_expect.pop_front();
					if (rsp_ch.data.out_port !== answer_due.out_port) begin
						$error("out_port: expected %0d, got %0d",
							answer_due.out_port, rsp_ch.data.out_port);
						mismatches++;
					end
					if (rsp_ch.data.route_status !== answer_due.route_status) begin
						$error("route_status: expected %0d, got %0d",
							answer_due.route_status, rsp_ch.data.route_status);
						mismatches++;
					end
					case (answer_due.route_status)
						ST_FOUND: ports_found++;
						ST_SAME:  same_answers++;
						default:  unreachable_answers++;
					endcase
				end
			end
			if (stall_span == 0) begin
				stall_mode <= ready_mode_e'($urandom_range(0, 2));
				stall_span <= $urandom_range(32, 200);
			end else begin
				stall_span <= stall_span - 1;
			end
			case (stall_mode)
				READY_ALWAYS: answer_ready <= 1'b1;
				READY_COIN:   answer_ready <= 1'($urandom_range(0, 1));
				default:      answer_ready <= stall_pattern[0];
			endcase
			stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
		end
	end

	// Drop the run if nothing moves for far longer than the slowest search,
	// the longest stall and the idle pause between settings put together.
	always @(posedge clk) begin
		if (!arst_n || (word_valid && req_ch.ready) || (rsp_ch.valid && answer_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == QUIET_LIMIT) begin
			$display("Timed out: %0d answers still due.", route_expect.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule
